@@ rtl/lfs_pkg.sv @@
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types, codes and helpers for the filtering letter sorter.
// ----------------------------------------------------------------------------
package lfs_pkg;

   localparam int unsigned CharWidth = 8;

   // item command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // ASCII letter bounds
   localparam logic [CharWidth-1:0] UPPER_FIRST = 8'h41;
   localparam logic [CharWidth-1:0] UPPER_LAST  = 8'h5A;
   localparam logic [CharWidth-1:0] LOWER_FIRST = 8'h61;
   localparam logic [CharWidth-1:0] LOWER_LAST  = 8'h7A;

   // operation broadcast to every cell in the same cycle
   typedef struct packed {
      logic                 push;
      logic                 pop;
      logic [CharWidth-1:0] letter;
   } cell_cmd_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic                 full;
      logic                 gt;     // full and holds a letter above the pushed one
      logic [CharWidth-1:0] data;
   } cell_link_type;

   function automatic logic is_letter(input logic [CharWidth-1:0] b);
      return ((b >= UPPER_FIRST) && (b <= UPPER_LAST)) ||
             ((b >= LOWER_FIRST) && (b <= LOWER_LAST));
   endfunction

endpackage

@@ rtl/lfs_cell.sv @@
// ----------------------------------------------------------------------------
// lfs_cell
// One slot of the sorting chain: holds one letter and a full bit, shifts
// right on an insert below it and left on a pop.
// ----------------------------------------------------------------------------
module lfs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lfs_pkg::cell_cmd_type cmd,
   input  lfs_pkg::cell_link_type left_link,
   input  lfs_pkg::cell_link_type right_link,
   output lfs_pkg::cell_link_type own_link
);

   logic                          full_ff, full_in;
   logic [lfs_pkg::CharWidth-1:0] data_ff, data_in;
   logic                          gt;

   // flag a stored letter that sorts after the pushed one
   assign gt = full_ff && (data_ff > cmd.letter);

   assign own_link.full = full_ff;
   assign own_link.gt   = gt;
   assign own_link.data = data_ff;

   // pick the next content of this slot
   always_comb begin
      full_in = full_ff;
      data_in = data_ff;
      if (cmd.pop) begin
         full_in = right_link.full;
         data_in = right_link.data;
      end else if (cmd.push) begin
         if (left_link.gt) begin
            full_in = left_link.full;
            data_in = left_link.data;
         end else if (gt || (!full_ff && left_link.full)) begin
            full_in = 1'b1;
            data_in = cmd.letter;
         end
      end
   end

   // clear the full bit under reset; the payload has no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

@@ rtl/letter_filter_sorter.sv @@
// ----------------------------------------------------------------------------
// letter_filter_sorter
// Keeps ASCII letters from a byte stream in ascending order in a chain of
// cells; a pop returns the smallest stored letter with status flags.
// ----------------------------------------------------------------------------
// A pop result appears on the rsp_ ports in the cycle after start.
// Throughput: one item per cycle; every cell compares and shifts in the same
// cycle, so busy stays low and the chain never stalls.
// Reset: synchronous, clears all full bits, the overflow flag and the strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.
module letter_filter_sorter #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic [lfs_pkg::CharWidth-1:0] req_char_in,
   output logic                          rsp_valid,
   output logic [lfs_pkg::CharWidth-1:0] rsp_letter_out,
   output logic                          rsp_was_empty,
   output logic                          rsp_last_letter,
   output logic                          rsp_overflowed
);

   lfs_pkg::cell_cmd_type  cmd;
   lfs_pkg::cell_link_type links [CAPACITY+2];

   logic                          accept;
   logic                          store_full;
   logic                          overflow_ff, overflow_in;
   logic                          valid_ff, valid_in;
   logic [lfs_pkg::CharWidth-1:0] letter_ff, letter_in;
   logic                          empty_ff, empty_in;
   logic                          last_ff, last_in;
   logic                          push_letter;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // decode the item and broadcast it down the chain
   assign store_full  = links[CAPACITY].full;
   assign push_letter = accept && (req_cmd == lfs_pkg::CMD_PUSH) &&
                        lfs_pkg::is_letter(req_char_in);
   assign cmd.push    = push_letter && !store_full;
   assign cmd.pop     = accept && (req_cmd == lfs_pkg::CMD_POP);
   assign cmd.letter  = req_char_in;

   // boundary links: a full never-greater slot on the left, an empty one on the right
   assign links[0].full           = 1'b1;
   assign links[0].gt             = 1'b0;
   assign links[0].data           = '0;
   assign links[CAPACITY+1].full  = 1'b0;
   assign links[CAPACITY+1].gt    = 1'b0;
   assign links[CAPACITY+1].data  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      lfs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_link  (links[i]),
         .right_link (links[i+2]),
         .own_link   (links[i+1])
      );
   end

   // form the pop result from the head of the chain
   always_comb begin
      overflow_in = overflow_ff || (push_letter && store_full);
      valid_in    = cmd.pop;
      empty_in    = !links[1].full;
      last_in     = links[1].full && !links[2].full;
      letter_in   = links[1].full ? links[1].data : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overflow_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         overflow_ff <= overflow_in;
         valid_ff    <= valid_in;
      end
   end

   // capture the payload only on a pop
   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         letter_ff <= letter_in;
         empty_ff  <= empty_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_letter_out  = letter_ff;
   assign rsp_was_empty   = empty_ff;
   assign rsp_last_letter = last_ff;
   assign rsp_overflowed  = overflow_ff;

endmodule
